// ----- rtl/fssa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fssa_pkg;

  localparam int MEM_DEPTH_DEF = 128;
  localparam int TOTAL_CAP     = 128;
  localparam int TOTAL_MIN     = 4;
  localparam int NUM_STACKS    = 4;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         stack_select;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         top_position;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/fssa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fssa_ctrl
  import fssa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output logic      out_valid,
  output dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC:  state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);
  assign cmd.load  = (state_r == S_IDLE) && start;
  assign cmd.exec  = (state_r == S_EXEC);

endmodule

`default_nettype wire

// ----- rtl/fssa_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fssa_dp
  import fssa_pkg::*;
#(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dp_cmd_t  cmd,
  input  wire in_item_t in_item,
  input  wire logic     cfg_we,
  input  wire logic [7:0] cfg_wdata,
  output out_item_t     out_item
);

  localparam int AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CAP = (MEM_DEPTH < TOTAL_CAP) ? MEM_DEPTH : TOTAL_CAP;

  logic [7:0]  total_r;
  logic [5:0]  counts_r [NUM_STACKS];
  in_item_t    item_r;
  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] rdata_r;
  logic        rd_ok_r;
  logic [1:0]  status_r;
  logic [6:0]  top_r;

  logic [7:0]  n_eff;
  logic [9:0]  n3;
  logic [7:0]  base, base_next;
  logic [5:0]  size, cnt_raw, cnt, cnt_new;
  logic [7:0]  idx, top_idx;
  logic        full, empty, do_wr, do_rd;
  logic [1:0]  status_nxt;

  always_comb begin
    if (total_r < 8'(TOTAL_MIN))  n_eff = 8'(TOTAL_MIN);
    else if (total_r > 8'(CAP))   n_eff = 8'(CAP);
    else                          n_eff = total_r;
    n3 = {2'b00, n_eff} + {1'b0, n_eff, 1'b0};
    case (item_r.stack_select)
      2'd0: begin base = 8'd0;              base_next = {2'b00, n_eff[7:2]}; end
      2'd1: begin base = {2'b00, n_eff[7:2]}; base_next = {1'b0, n_eff[7:1]}; end
      2'd2: begin base = {1'b0, n_eff[7:1]}; base_next = n3[9:2]; end
      default: begin base = n3[9:2];        base_next = n_eff; end
    endcase
    size    = 6'(base_next - base);
    cnt_raw = counts_r[item_r.stack_select];
    cnt     = (cnt_raw > size) ? size : cnt_raw;
    full    = (cnt >= size);
    empty   = (cnt == 6'd0);
    do_wr   = 1'b0;
    do_rd   = 1'b0;
    cnt_new = cnt;
    status_nxt = ST_OK;
    idx     = base + {2'b00, cnt};
    case (item_r.mode)
      MODE_PUSH: begin
        if (full) status_nxt = ST_OVERFLOW;
        else begin
          do_wr   = 1'b1;
          cnt_new = cnt + 6'd1;
        end
      end
      MODE_POP, MODE_PEEK: begin
        idx = base + {2'b00, cnt} - 8'd1;
        if (empty) status_nxt = ST_EMPTY;
        else begin
          do_rd = 1'b1;
          if (item_r.mode == MODE_POP) cnt_new = cnt - 6'd1;
        end
      end
      default: ;
    endcase
    top_idx = base + {2'b00, cnt_new} - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 8'd128;
      for (int k = 0; k < NUM_STACKS; k++) counts_r[k] <= '0;
    end else if (cfg_we) begin
      total_r <= cfg_wdata;
      for (int k = 0; k < NUM_STACKS; k++) counts_r[k] <= '0;
    end else if (cmd.exec) begin
      counts_r[item_r.stack_select] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.exec) begin
      rd_ok_r  <= do_rd;
      status_r <= status_nxt;
      top_r    <= (cnt_new == 6'd0) ? 7'd0 : top_idx[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (do_wr) mem[AW'(idx)] <= item_r.push_value;
      rdata_r <= mem[AW'(idx)];
    end
  end

  assign out_item.read_value   = rd_ok_r ? rdata_r : 32'sd0;
  assign out_item.status       = status_r;
  assign out_item.top_position = top_r;

endmodule

`default_nettype wire

// ----- rtl/four_stacks_shared_array_unit.sv -----
// Channel     Ports                        Handshake
// input       start, busy, in_item         taken when start && !busy
// result      out_valid, out_item          one-cycle strobe, no backpressure
// config      cfg_we, cfg_wdata            taken when cfg_we, clears all stacks
//
// Each transaction passes through capture, one memory access and the result strobe.
// The single-port word memory is read once per transaction and also written on a push.
// busy stays high from acceptance until the result strobe cycle ends.
// Reset empties all stacks and sets the total to 128; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module four_stacks_shared_array_unit
  import fssa_pkg::*;
#(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  output out_item_t       out_item,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  dp_cmd_t cmd;

  fssa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  fssa_dp #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted transaction did not raise busy");

  a_result_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy held after result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_EMPTY |->
      out_item.read_value == 32'sd0 && out_item.top_position == 7'd0)
    else $error("empty result carries data");

  a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_OVERFLOW |-> out_item.read_value == 32'sd0)
    else $error("overflow result carries data");

endmodule

`default_nettype wire

// ----- test/tb_four_stacks_shared_array_unit.sv -----
`timescale 1ns / 1ps

module tb_four_stacks_shared_array_unit;
  import fssa_pkg::*;

  localparam int DEPTH = MEM_DEPTH_DEF;
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int PHASE_ITEMS = 95;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_item_t   in_item   = '0;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;

  four_stacks_shared_array_unit #(.MEM_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the stack engine
  logic [31:0] shadow_mem [DEPTH];
  int unsigned shadow_count [NUM_STACKS];
  int unsigned shadow_total;

  out_item_t   pending_results [$];
  int unsigned error_count;
  int unsigned checked_count;
  int unsigned overflow_count;
  int unsigned empty_count;
  int unsigned total_writes;
  bit          idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic out_item_t predict_stack_op(in_item_t op_item);
    int unsigned n, cap, sel, base, size, cnt;
    out_item_t r;
    r = '0;
    cap = (DEPTH < TOTAL_CAP) ? DEPTH : TOTAL_CAP;
    n = shadow_total;
    if (n > cap) n = cap;
    if (n < TOTAL_MIN) n = TOTAL_MIN;
    sel = op_item.stack_select;
    base = sel * n / 4;
    size = (sel + 1) * n / 4 - base;
    cnt = shadow_count[sel];
    if (cnt > size) cnt = size;
    r.status = ST_OK;
    case (op_item.mode)
      MODE_PUSH: begin
        if (cnt >= size) begin
          r.status = ST_OVERFLOW;
        end else begin
          shadow_mem[base + cnt] = op_item.push_value;
          cnt++;
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_value = shadow_mem[base + cnt - 1];
          if (op_item.mode == MODE_POP) cnt--;
        end
      end
      default: ;
    endcase
    shadow_count[sel] = cnt;
    r.top_position = (cnt == 0) ? 7'd0 : 7'(base + cnt - 1);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (error_count < 30)
      $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $time, field, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(out_item), 32'd0);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (want.status == ST_OVERFLOW) overflow_count++;
        if (want.status == ST_EMPTY) empty_count++;
        if (out_item.read_value !== want.read_value)
          report_mismatch("read_value", out_item.read_value, want.read_value);
        if (out_item.status !== want.status)
          report_mismatch("status", 32'(out_item.status), 32'(want.status));
        if (out_item.top_position !== want.top_position)
          report_mismatch("top_position", 32'(out_item.top_position), 32'(want.top_position));
      end
    end
  end

  task automatic send_op(logic [1:0] op, logic [1:0] sel, logic [31:0] value);
    in_item_t op_item;
    int unsigned gap;
    op_item.mode = op;
    op_item.stack_select = sel;
    op_item.push_value = value;
    gap = idle_on ? $urandom_range(19) : 0;
    in_item <= op_item;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_stack_op(op_item));
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_total(logic [7:0] value);
    drain_results();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_total = value;
    shadow_count = '{default: 0};
    total_writes++;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_after_reset();
    int s;
    for (s = 0; s < NUM_STACKS; s++) begin
      send_op(MODE_POP, 2'(s), $urandom);
      send_op(MODE_PEEK, 2'(s), $urandom);
    end
    send_op(MODE_NOP, 2'd2, $urandom);
  endtask

  task automatic test_value_extremes();
    send_op(MODE_PUSH, 2'd0, 32'h8000_0000);
    send_op(MODE_PUSH, 2'd1, 32'h7fff_ffff);
    send_op(MODE_PUSH, 2'd2, 32'h0000_0000);
    send_op(MODE_PUSH, 2'd3, 32'hffff_ffff);
    send_op(MODE_PUSH, 2'd0, 32'h5555_5555);
    send_op(MODE_PUSH, 2'd0, 32'haaaa_aaaa);
    send_op(MODE_NOP, 2'd0, $urandom);
    send_op(MODE_PEEK, 2'd0, $urandom);
    send_op(MODE_POP, 2'd0, $urandom);
    send_op(MODE_POP, 2'd0, $urandom);
    send_op(MODE_PEEK, 2'd3, $urandom);
    send_op(MODE_POP, 2'd1, $urandom);
  endtask

  task automatic test_smallest_regions();
    write_total(8'd0);
    send_op(MODE_PUSH, 2'd0, $urandom);
    send_op(MODE_PUSH, 2'd0, $urandom);
    send_op(MODE_PUSH, 2'd3, $urandom);
    send_op(MODE_PUSH, 2'd3, $urandom);
    send_op(MODE_PEEK, 2'd3, $urandom);
    // rewrite clears every stack
    write_total(8'd255);
    send_op(MODE_PEEK, 2'd0, $urandom);
  endtask

  task automatic test_random_traffic();
    logic [7:0] totals [11];
    int unsigned k, i, push_pct;
    logic [1:0] op, sel, focus;
    totals = '{8'd128, 8'd7, 8'd5, 8'd6, 8'd255, 8'd127, 8'd9, 8'd64, 8'd2, 8'd33, 8'd0};
    totals[10] = 8'($urandom_range(255));
    for (k = 0; k < 11; k++) begin
      write_total(totals[k]);
      focus = 2'($urandom_range(3));
      for (i = 0; i < PHASE_ITEMS; i++) begin
        idle_on = ((i / 24) % 3) != 1;
        if (k == 0 && i == 50) drain_results();
        push_pct = (i < 60) ? 85 : 25;
        if ($urandom_range(99) < push_pct) begin
          op = MODE_PUSH;
        end else begin
          case ($urandom_range(9))
            0: op = MODE_NOP;
            1, 2, 3: op = MODE_PEEK;
            default: op = MODE_POP;
          endcase
        end
        sel = ($urandom_range(99) < 70) ? focus : 2'($urandom_range(3));
        send_op(op, sel, pick_value());
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    shadow_total = 128;
    shadow_count = '{default: 0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_after_reset();
    test_value_extremes();
    test_smallest_regions();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d transactions over %0d total settings (extremes and clamped values).",
             checked_count, total_writes);
    $display("Overflow results: %0d, empty results: %0d.", overflow_count, empty_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fssa_pkg.sv
rtl/fssa_ctrl.sv
rtl/fssa_dp.sv
rtl/four_stacks_shared_array_unit.sv
test/tb_four_stacks_shared_array_unit.sv
